[rtl/i2c_master_bit_sequencer_core_macros.svh]
// ----------------------------------------------------------------------------
// I2C bit sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2CBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/i2cbs_pkg.sv]
// ----------------------------------------------------------------------------
// I2C bit sequencer package
// Shared constants, item type and small decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam int unsigned STEP_W = 5;
	localparam int unsigned HOLD_W = 16;
	localparam logic [HOLD_W-1:0] STEP_TICKS_RESET = 16'd10;
	localparam logic [STEP_W-1:0] BYTE_SEQ_STEPS = 5'd28;
	localparam logic [STEP_W-1:0] START_SEQ_STEPS = 5'd4;
	localparam logic [STEP_W-1:0] STOP_SEQ_STEPS = 5'd3;
	localparam logic [STEP_W-1:0] BIT_STEPS_END = 5'd24;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] operation;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [2:0] bit_idx;
		logic [1:0] phase;
	} bit_phase_t;

	function automatic logic [STEP_W-1:0] seq_length(input logic [1:0] op);
		logic [STEP_W-1:0] len;
		unique case (op)
			OP_START: len = START_SEQ_STEPS;
			OP_STOP:  len = STOP_SEQ_STEPS;
			default:  len = BYTE_SEQ_STEPS;
		endcase
		return len;
	endfunction

	// Splits a step number below 24 into a bit number and a phase of three.
	function automatic bit_phase_t split3(input logic [STEP_W-1:0] k);
		logic [9:0] prod;
		logic [2:0] b;
		logic [STEP_W-1:0] rem;
		bit_phase_t r;
		prod = 10'(k) * 10'd11;
		b = prod[7:5];
		rem = k - (STEP_W'(b) + STEP_W'(b) + STEP_W'(b));
		r.bit_idx = b;
		r.phase = rem[1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/i2cbs_in_reg.sv]
// ----------------------------------------------------------------------------
// I2C bit sequencer input register
// Holds one accepted tick item until the sequencer stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire i2cbs_pkg::item_t in_item,
	input  wire logic            adv,
	output logic                 valid_s1,
	output i2cbs_pkg::item_t     item_s1
);
	import i2cbs_pkg::*;

	logic take;

	assign in_stall = valid_s1 && !adv;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

[rtl/i2cbs_seq.sv]
// ----------------------------------------------------------------------------
// I2C bit sequencer step stage
// Advances the pin sequence by one tick and registers the tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_sequencer_core_macros.svh"

module i2cbs_seq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid_s1,
	input  wire i2cbs_pkg::item_t             item_s1,
	input  wire logic [i2cbs_pkg::HOLD_W-1:0] step_ticks,
	output logic                              adv,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              scl_out,
	output logic                              sda_out,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [7:0]                        rx_byte,
	output logic                              ack_received
);
	import i2cbs_pkg::*;

	logic              running_q;
	logic [1:0]        op_q;
	logic [STEP_W-1:0] step_q;
	logic [HOLD_W-1:0] hold_q;
	logic [7:0]        shift_q;
	logic              ack_latch_q;
	logic              scl_q;
	logic              sda_q;
	logic              ack_seen_q;
	logic [7:0]        rx_q;
	logic              busy_q;
	logic              done_q;
	logic              out_valid_q;

	logic              run_n;
	logic [1:0]        op_n;
	logic [STEP_W-1:0] step_n;
	logic [HOLD_W-1:0] hold_n;
	logic [7:0]        shift_n;
	logic              ack_latch_n;
	logic              scl_n;
	logic              sda_n;
	logic              ack_seen_n;
	logic [7:0]        rx_n;
	logic              busy_n;
	logic              done_n;
	bit_phase_t        wr_bp;
	bit_phase_t        rd_bp;
	logic [STEP_W-1:0] rd_j;

	assign adv = valid_s1 && (!out_valid_q || !out_stall);

	always_comb begin
		run_n = running_q;
		op_n = op_q;
		step_n = step_q;
		hold_n = hold_q;
		shift_n = shift_q;
		ack_latch_n = ack_latch_q;
		scl_n = scl_q;
		sda_n = sda_q;
		ack_seen_n = ack_seen_q;
		rx_n = rx_q;
		busy_n = 1'b0;
		done_n = 1'b0;

		if (!running_q && item_s1.cmd_valid) begin
			run_n = 1'b1;
			op_n = item_s1.operation;
			step_n = '0;
			hold_n = '0;
			shift_n = (item_s1.operation == OP_WRITE) ? item_s1.tx_byte : 8'h00;
			ack_latch_n = item_s1.ack_to_send;
		end

		wr_bp = split3(step_n);
		rd_j = step_n - STEP_W'(1);
		rd_bp = split3(rd_j);

		if (run_n) begin
			busy_n = 1'b1;
			if (hold_n == '0) begin
				unique case (op_n)
					OP_START: begin
						unique case (step_n)
							5'd0:    sda_n = 1'b1;
							5'd1:    scl_n = 1'b1;
							5'd2:    sda_n = 1'b0;
							default: scl_n = 1'b0;
						endcase
					end
					OP_STOP: begin
						unique case (step_n)
							5'd0:    sda_n = 1'b0;
							5'd1:    scl_n = 1'b1;
							default: sda_n = 1'b1;
						endcase
					end
					OP_WRITE: begin
						if (step_n < BIT_STEPS_END) begin
							unique case (wr_bp.phase)
								2'd0:    sda_n = shift_n[3'd7 - wr_bp.bit_idx];
								2'd1:    scl_n = 1'b1;
								default: scl_n = 1'b0;
							endcase
						end else begin
							unique case (step_n)
								5'd24:   sda_n = 1'b1;
								5'd25:   scl_n = 1'b1;
								5'd26:   ack_seen_n = item_s1.sda_in;
								default: scl_n = 1'b0;
							endcase
						end
					end
					default: begin
						if (step_n == '0) begin
							sda_n = 1'b1;
						end else if (step_n <= BIT_STEPS_END) begin
							unique case (rd_bp.phase)
								2'd0:    scl_n = 1'b1;
								2'd1: begin
									if (item_s1.sda_in) begin
										shift_n[3'd7 - rd_bp.bit_idx] = 1'b1;
									end
								end
								default: scl_n = 1'b0;
							endcase
						end else begin
							unique case (step_n)
								5'd25:   sda_n = ack_latch_n;
								5'd26:   scl_n = 1'b1;
								default: scl_n = 1'b0;
							endcase
						end
					end
				endcase
				hold_n = (step_ticks == '0) ? HOLD_W'(1) : step_ticks;
			end
			hold_n = hold_n - HOLD_W'(1);
			if (hold_n == '0) begin
				step_n = step_n + STEP_W'(1);
				if (step_n >= seq_length(op_n)) begin
					run_n = 1'b0;
					done_n = 1'b1;
					step_n = '0;
					if (op_n == OP_READ) begin
						rx_n = shift_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			op_q <= OP_START;
			step_q <= '0;
			hold_q <= '0;
			shift_q <= '0;
			ack_latch_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			ack_seen_q <= 1'b1;
			rx_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (adv) begin
			running_q <= run_n;
			op_q <= op_n;
			step_q <= step_n;
			hold_q <= hold_n;
			shift_q <= shift_n;
			ack_latch_q <= ack_latch_n;
			scl_q <= scl_n;
			sda_q <= sda_n;
			ack_seen_q <= ack_seen_n;
			rx_q <= rx_n;
			busy_q <= busy_n;
			done_q <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out = scl_q;
	assign sda_out = sda_q;
	assign busy_res = busy_q;
	assign done_res = done_q;
	assign rx_byte = rx_q;
	assign ack_received = ack_seen_q;

	`I2CBS_ASSERT_SAME(a_done_busy, out_valid_q && done_q, busy_q && !running_q, "done without busy")
	`I2CBS_ASSERT_SAME(a_hold_running, hold_q != '0, running_q, "hold count set while idle")
	`I2CBS_ASSERT_SAME(a_step_range, 1'b1, step_q < BYTE_SEQ_STEPS, "step index out of range")
	`I2CBS_ASSERT_NEXT(a_state_hold, !adv, $stable(step_q) && $stable(hold_q), "state moved without advance")

endmodule

`default_nettype wire

[rtl/i2c_master_bit_sequencer_core.sv]
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain pin sequencer for start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
// Each input transfer is one time tick carrying an optional command and the
// sampled SDA level; each tick yields exactly one output transfer with the
// SCL and SDA drive, busy and done flags, the last read byte and the last
// write acknowledge. Ticks enter through an input register and the result
// is registered in the step stage. One tick is taken every cycle while the
// receiver does not stall; the rate is set by the single step stage.
// Every pin action is held for step_ticks ticks, or one tick when it is zero.
// step_ticks is set through the write-only configuration channel; the user
// must write it only while no sequence runs, as the block does not enforce
// this. It resets to 10. Reset releases both lines, clears busy, sets the
// acknowledge flag to one and the received byte to zero. When the receiver
// stalls, the result is held and, once the input register is full, in_stall
// is raised so that no tick is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         cmd_valid,
	input  wire logic [1:0]                   operation,
	input  wire logic [7:0]                   tx_byte,
	input  wire logic                         ack_to_send,
	input  wire logic                         sda_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              scl_out,
	output logic                              sda_out,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [7:0]                        rx_byte,
	output logic                              ack_received,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [i2cbs_pkg::HOLD_W-1:0] cfg_data
);
	import i2cbs_pkg::*;

	item_t             in_item;
	item_t             item_s1;
	logic              valid_s1;
	logic              adv;
	logic [HOLD_W-1:0] step_ticks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= STEP_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_ticks_q <= cfg_data;
		end
	end

	assign in_item.cmd_valid = cmd_valid;
	assign in_item.operation = operation;
	assign in_item.tx_byte = tx_byte;
	assign in_item.ack_to_send = ack_to_send;
	assign in_item.sda_in = sda_in;

	i2cbs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cbs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.step_ticks   (step_ticks_q),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_out      (scl_out),
		.sda_out      (sda_out),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.rx_byte      (rx_byte),
		.ack_received (ack_received)
	);

endmodule

`default_nettype wire
